/* rtl/kbs_pkg.sv */
package kbs_pkg;

	typedef logic signed [31:0] time_t;

	localparam int TIME_W  = 32;
	localparam int OIDX_W  = 6;
	localparam int KIND_W  = 2;
	localparam int ACT_W   = 2;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_NORMAL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STATIC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_WRAP    = 2'd3;

endpackage

/* rtl/kbs_mem.sv */
module kbs_mem
	import kbs_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  time_t         wdata,
	input  logic [AW-1:0] raddr,
	output time_t         rdata
);

	time_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/kbs_rem.sv */
module kbs_rem
	import kbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  time_t dividend,
	input  time_t divisor,
	output logic  done,
	output time_t rem
);

	logic [TIME_W-1:0] q_q;
	logic [TIME_W-1:0] d_q;
	logic [TIME_W-1:0] r_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [TIME_W:0]   sh;
	logic [TIME_W:0]   diff;
	logic [TIME_W-1:0] r_next;
	logic [TIME_W-1:0] mag_a;
	logic [TIME_W-1:0] mag_b;

	assign mag_a = dividend[TIME_W-1] ? (TIME_W'(0) - dividend) : dividend;
	assign mag_b = divisor[TIME_W-1] ? (TIME_W'(0) - divisor) : divisor;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		sh     = {r_q, q_q[TIME_W-1]};
		diff   = sh - {1'b0, d_q};
		r_next = (sh >= {1'b0, d_q}) ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag_a;
			d_q   <= mag_b;
			r_q   <= '0;
			neg_q <= dividend[TIME_W-1];
		end else if (busy_q) begin
			r_q <= r_next;
			q_q <= {q_q[TIME_W-2:0], 1'b0};
		end
	end

	// remainder takes the sign of the dividend
	assign rem  = neg_q ? (TIME_W'(0) - r_q) : r_q;
	assign done = done_q;

endmodule

/* rtl/keyframe_bracket_search.sv */
// Keyframe bracket search.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the action
// (clear, append, query) and the NaN flag, s_tdata the Q16.16 time.
// Clear and append give no output word. An append to a
// full table is dropped.
// A query gives one output word on m_tvalid/m_tready: m_tuser is the result
// kind, m_tdata the two key indices and the wrapped time.
// A NaN query or one against an empty table goes straight to the finish state;
// one with a zero last time first reads the last key. Otherwise the query reads
// the last key, runs a 32-step restoring remainder and then scans the key store
// through its single read port, one entry per cycle.
// One item is in work at a time; s_tready is high only when no item is
// in work. A finished result waits in the output register while the
// receiver stalls; a query that completes behind it holds until the word
// is taken.
// Reset empties the table and drops any pending output; the store contents
// are left as they are and are never read before being written.
module keyframe_bracket_search
	import kbs_pkg::*;
#(
	parameter int MAX_KEYS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] time_value
	input  logic [2:0]  s_tuser,  // [1:0] action, [2] query_not_a_number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [5:0] first_index, [11:6] second_index,
	                              // [43:12] wrapped_time, [47:44] zero
	output logic [1:0]  m_tuser   // [1:0] result_kind
);

	localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LAST = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] key_count_q;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] last_idx;
	logic [CNT_W-1:0] scan_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	time_t            qtime_q;
	time_t            wt_q;
	logic [IDX_W-1:0] x_q;
	logic [IDX_W-1:0] y_q;
	logic             found_q;
	logic             before_q;

	logic [KIND_W-1:0] res_kind_q;
	logic [IDX_W-1:0]  res_first_q;
	logic [IDX_W-1:0]  res_second_q;
	time_t             res_time_q;

	logic              m_tvalid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [OIDX_W-1:0] out_first_q;
	logic [OIDX_W-1:0] out_second_q;
	time_t             out_time_q;

	logic              accept;
	logic [ACT_W-1:0]  action;
	logic              is_nan;
	time_t             in_time;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_raddr;
	time_t             mem_rdata;
	logic              rem_start;
	logic              rem_done;
	time_t             rem_val;
	logic              ge;
	logic              le;
	logic [IDX_W-1:0]  x_next;
	logic [IDX_W-1:0]  y_next;
	logic              found_next;
	logic              before_next;
	logic [IDX_W+OIDX_W-1:0] first_ext;
	logic [IDX_W+OIDX_W-1:0] second_ext;

	assign action  = s_tuser[1:0];
	assign is_nan  = s_tuser[2];
	assign in_time = s_tdata;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cnt_m1   = key_count_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];

	assign mem_we    = accept && (action == ACT_APPEND) && (key_count_q < MAX_CNT);
	assign mem_raddr = (state_q == ST_SCAN) ? scan_idx_q[IDX_W-1:0] : last_idx;

	kbs_mem #(
		.DEPTH (MAX_KEYS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (key_count_q[IDX_W-1:0]),
		.wdata (in_time),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rem_start = (state_q == ST_LAST) && (mem_rdata != '0);

	kbs_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (qtime_q),
		.divisor  (mem_rdata),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// fold the entry now on the read port into the bracket
	always_comb begin
		ge          = (mem_rdata >= wt_q);
		le          = (mem_rdata <= wt_q);
		x_next      = x_q;
		found_next  = found_q;
		y_next      = y_q;
		before_next = before_q;
		if (cmp_vld_s1) begin
			if (ge && !found_q) begin
				x_next     = cmp_idx_s1;
				found_next = 1'b1;
			end
			if (le) begin
				y_next = cmp_idx_s1;
			end
			if (cmp_idx_s1 == '0) begin
				before_next = (mem_rdata > wt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			cmp_vld_s1  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_CLEAR: begin
								key_count_q <= '0;
							end
							ACT_APPEND: begin
								if (key_count_q < MAX_CNT) begin
									key_count_q <= key_count_q + CNT_W'(1);
								end
							end
							ACT_QUERY: begin
								if (is_nan || key_count_q == '0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_LAST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LAST: begin
					state_q <= (mem_rdata == '0) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (rem_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmp_vld_s1 && cmp_idx_s1 == last_idx) begin
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_FIN;
					end else begin
						cmp_vld_s1 <= (scan_idx_q < key_count_q);
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qtime_q      <= in_time;
				res_first_q  <= '0;
				res_second_q <= '0;
				res_time_q   <= '0;
				res_kind_q   <= (is_nan && key_count_q == CNT_W'(1)) ? KIND_STATIC
				                                                     : KIND_DEFAULT;
			end
			ST_LAST: begin
				res_kind_q <= KIND_DEFAULT;
			end
			ST_DIV: begin
				wt_q       <= rem_val;
				scan_idx_q <= '0;
				x_q        <= last_idx;
				y_q        <= '0;
				found_q    <= 1'b0;
				before_q   <= 1'b0;
			end
			ST_SCAN: begin
				if (scan_idx_q < key_count_q) begin
					cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				x_q      <= x_next;
				y_q      <= y_next;
				found_q  <= found_next;
				before_q <= before_next;
				if (before_next) begin
					res_kind_q   <= KIND_WRAP;
					res_first_q  <= last_idx;
					res_second_q <= '0;
				end else begin
					res_kind_q   <= KIND_NORMAL;
					res_first_q  <= x_next;
					res_second_q <= y_next;
				end
				res_time_q <= wt_q;
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_kind_q   <= res_kind_q;
					out_first_q  <= first_ext[OIDX_W-1:0];
					out_second_q <= second_ext[OIDX_W-1:0];
					out_time_q   <= res_time_q;
				end
			end
			default: begin
			end
		endcase
	end

	// report indices in their low six bits whatever the table depth
	assign first_ext  = {{OIDX_W{1'b0}}, res_first_q};
	assign second_ext = {{OIDX_W{1'b0}}, res_second_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {4'b0000, out_time_q, out_second_q, out_first_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= MAX_CNT)
		else $error("key count above table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> ({1'b0, cmp_idx_s1} < {1'b0, key_count_q}))
		else $error("scan compares an entry beyond the stored keys");

	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_DIV))
		else $error("remainder finished outside its wait state");

	a_start_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |=> (state_q == ST_DIV))
		else $error("remainder started without moving to its wait state");
`endif

endmodule

/* test/keyframe_bracket_search_tb.sv */
module keyframe_bracket_search_tb
	import kbs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     KEY_DEPTH = 64;
	localparam longint TIME_MAX  = 64'sd2147483647;
	localparam longint TIME_MIN  = -64'sd2147483648;

	// action code with no function
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OIDX_W-1:0] first_idx;
		logic [OIDX_W-1:0] second_idx;
		time_t             wrapped;
	} bracket_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	// mirror of the key table
	time_t    key_store [KEY_DEPTH];
	int       key_count = 0;
	bracket_t pending_brackets [$];

	int sent_items  = 0;
	int mismatches  = 0;
	int hold_cycles = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;

	keyframe_bracket_search #(
		.MAX_KEYS(KEY_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("keyframe_bracket_search: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic time_t to_time(longint v);
		if (v > TIME_MAX)
			return time_t'(TIME_MAX);
		if (v < TIME_MIN)
			return time_t'(TIME_MIN);
		return time_t'(v);
	endfunction

	// bracket of a query against the current table
	function automatic bracket_t bracket_for(time_t t, logic nan);
		bracket_t b;
		longint   last_time;
		longint   w;
		int       hi;
		int       lo;
		b = '{kind: KIND_DEFAULT, first_idx: '0, second_idx: '0, wrapped: '0};
		if (nan) begin
			if (key_count == 1)
				b.kind = KIND_STATIC;
			return b;
		end
		last_time = (key_count == 0) ? 0 : longint'(key_store[key_count-1]);
		if (last_time == 0)
			return b;
		// truncating remainder, sign follows the query time
		w = longint'(t) % last_time;
		b.wrapped = time_t'(w);
		if (w < longint'(key_store[0])) begin
			b.kind      = KIND_WRAP;
			b.first_idx = OIDX_W'(key_count - 1);
			return b;
		end
		hi = key_count - 1;
		for (int i = key_count - 1; i >= 0; i--)
			if (longint'(key_store[i]) >= w)
				hi = i;
		lo = 0;
		for (int i = 0; i < key_count; i++)
			if (longint'(key_store[i]) <= w)
				lo = i;
		b.kind       = KIND_NORMAL;
		b.first_idx  = OIDX_W'(hi);
		b.second_idx = OIDX_W'(lo);
		return b;
	endfunction

	function automatic void track_word(logic [ACT_W-1:0] act, time_t t, logic nan);
		case (act)
			ACT_CLEAR: key_count = 0;
			ACT_APPEND: begin
				if (key_count < KEY_DEPTH) begin
					key_store[key_count] = t;
					key_count++;
				end
			end
			ACT_QUERY: pending_brackets.insert(pending_brackets.size(), bracket_for(t, nan));
			default: ;
		endcase
	endfunction

	task automatic send_word(logic [ACT_W-1:0] act, time_t t, logic nan);
		int gap;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		s_tuser  <= {nan, act};
		do
			@(posedge clk);
		while (!s_tready);
		track_word(act, t, nan);
		if (act == ACT_CLEAR || act == ACT_APPEND || act == ACT_QUERY)
			sent_items++;
	endtask

	function automatic time_t pick_query_time();
		longint last_time;
		longint v;
		int     r;
		r = $urandom_range(0, 9);
		if (r < 3 || key_count == 0)
			return time_t'($urandom);
		last_time = longint'(key_store[key_count-1]);
		if (r < 7) begin
			// near a stored key, shifted by a few loop lengths
			v = longint'(key_store[$urandom_range(0, key_count - 1)])
				+ longint'($urandom_range(0, 4)) - 2
				+ last_time * (longint'($urandom_range(0, 6)) - 3);
		end else begin
			v = (longint'($urandom_range(0, 1000)) - 500) * last_time / 250;
		end
		return to_time(v);
	endfunction

	task automatic fill_table(int n);
		longint stamp;
		longint v;
		int     shape;
		bit     zero_end;
		if ($urandom_range(0, 9) != 0)
			send_word(ACT_CLEAR, time_t'($urandom), 1'($urandom_range(0, 1)));
		shape    = $urandom_range(0, 19);
		zero_end = ($urandom_range(0, 19) == 0);
		if (shape < 13)
			stamp = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 32'h30000));
		else if (shape < 16)
			stamp = -longint'(n) * 64'sh40000 - longint'($urandom_range(0, 32'h40000));
		else if (shape < 18)
			stamp = 0;
		else
			stamp = 64'sh7FFF0000;
		for (int i = 0; i < n; i++) begin
			if (shape == 16 || shape == 17)
				v = longint'(time_t'($urandom));
			else
				v = stamp;
			if (zero_end && i == n - 1)
				v = 0;
			send_word(ACT_APPEND, to_time(v), $urandom_range(0, 7) == 0);
			stamp += ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(1, 32'h40000));
		end
	endtask

	function automatic int pick_table_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 24);
		return $urandom_range(50, 70);
	endfunction

	task automatic test_empty_table();
		send_word(ACT_QUERY, 32'h0001_0000, 1'b0);
		send_word(ACT_QUERY, 32'h0000_0000, 1'b1);
		send_word(ACT_SPARE, 32'hFFFF_FFFF, 1'b1);
		send_word(ACT_CLEAR, 32'h0000_0000, 1'b0);
	endtask

	task automatic test_single_key();
		send_word(ACT_CLEAR, 32'h0, 1'b0);
		send_word(ACT_APPEND, 32'h0001_0000, 1'b0);
		send_word(ACT_QUERY, 32'h0, 1'b1);
		send_word(ACT_QUERY, 32'h0000_8000, 1'b0);
		send_word(ACT_QUERY, 32'h0001_8000, 1'b0);
		send_word(ACT_QUERY, -32'sh8000, 1'b0);
	endtask

	task automatic test_zero_last();
		send_word(ACT_CLEAR, 32'h0, 1'b0);
		send_word(ACT_APPEND, -32'sh5000, 1'b0);
		send_word(ACT_APPEND, 32'h0, 1'b0);
		send_word(ACT_QUERY, 32'h1234_5678, 1'b0);
	endtask

	task automatic test_extremes();
		send_word(ACT_CLEAR, 32'h0, 1'b0);
		send_word(ACT_APPEND, 32'h8000_0000, 1'b1);
		send_word(ACT_APPEND, 32'h7FFF_FFFF, 1'b0);
		send_word(ACT_QUERY, 32'h7FFF_FFFF, 1'b0);
		send_word(ACT_QUERY, 32'h8000_0000, 1'b0);
		send_word(ACT_QUERY, 32'hFFFF_FFFF, 1'b0);
		send_word(ACT_QUERY, 32'h0, 1'b1);
	endtask

	// negative keys: nothing at or after the wrapped time, first index saturates
	task automatic test_negative_table();
		send_word(ACT_CLEAR, 32'h0, 1'b0);
		send_word(ACT_APPEND, -32'sh30000, 1'b0);
		send_word(ACT_APPEND, -32'sh10000, 1'b0);
		send_word(ACT_QUERY, -32'sh8000, 1'b0);
		send_word(ACT_QUERY, -32'sh1C000, 1'b0);
		send_word(ACT_QUERY, 32'sh40000, 1'b0);
	endtask

	task automatic test_full_table();
		repeat (2) begin
			fill_table($urandom_range(64, 70));
			repeat (8)
				send_word(ACT_QUERY, pick_query_time(), 1'b0);
		end
	endtask

	task automatic test_back_to_back();
		send_steady = 1'b1;
		recv_steady = 1'b1;
		repeat (4) begin
			fill_table($urandom_range(1, 6));
			repeat (20)
				send_word(ACT_QUERY, pick_query_time(), $urandom_range(0, 9) == 0);
		end
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	// receiver holds off while queries keep coming, so the output word and
	// the one behind it back up into the input
	task automatic test_backpressure();
		fill_table(8);
		send_steady = 1'b1;
		hold_cycles = 300;
		repeat (10)
			send_word(ACT_QUERY, pick_query_time(), 1'b0);
		send_steady = 1'b0;
	endtask

	task automatic test_random_sequences(int item_goal);
		int stop_at;
		stop_at = sent_items + item_goal;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				fill_table(pick_table_size());
				repeat ($urandom_range(1, 12))
					send_word(ACT_QUERY, pick_query_time(), $urandom_range(0, 15) == 0);
			end else begin
				repeat ($urandom_range(1, 6))
					send_word(2'($urandom_range(0, 3)), time_t'($urandom),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic report(string what, bracket_t want, bracket_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected kind %0d first %0d second %0d time %h,",
				$realtime, what, want.kind, want.first_idx, want.second_idx, want.wrapped,
				" got kind %0d first %0d second %0d time %h",
				got.kind, got.first_idx, got.second_idx, got.wrapped);
	endtask

	always @(posedge clk) begin : check_results
		bracket_t want;
		bracket_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind       = m_tuser;
			got.first_idx  = m_tdata[5:0];
			got.second_idx = m_tdata[11:6];
			got.wrapped    = m_tdata[43:12];
			if (pending_brackets.size() == 0) begin
				report("unexpected word", '0, got);
			end else begin
				want = pending_brackets.pop_front();
				if (got.kind != want.kind || got.first_idx != want.first_idx
						|| got.second_idx != want.second_idx || got.wrapped != want.wrapped)
					report("wrong word", want, got);
			end
		end
	end

	initial begin : receiver
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = recv_steady ? 0 : pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		arst_n   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_single_key();
		test_zero_last();
		test_extremes();
		test_negative_table();
		test_full_table();
		test_back_to_back();
		test_backpressure();
		test_random_sequences(1200 - sent_items);

		// drain: wait for every query, then wait on for any stray output word
		s_tvalid <= 1'b0;
		while (pending_brackets.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		if (mismatches == 0 && pending_brackets.size() == 0)
			$display("keyframe_bracket_search: match");
		else
			$display("keyframe_bracket_search: mismatch");
		$finish;
	end

endmodule
